>>> src/cflb_pkg.sv
// Shared types and constants of the CPU frequency limit booster.
package cflb_pkg;

	// Field widths.
	localparam int FREQ_BITS    = 22;
	localparam int TIME_BITS    = 16;
	localparam int REG_IDX_BITS = 3;

	// Event codes; the two codes above OP_INIT are ignored.
	localparam logic [2:0] OP_TICK      = 3'd0;
	localparam logic [2:0] OP_SCREEN    = 3'd1;
	localparam logic [2:0] OP_INTERACT  = 3'd2;
	localparam logic [2:0] OP_LAUNCH    = 3'd3;
	localparam logic [2:0] OP_LOW_POWER = 3'd4;
	localparam logic [2:0] OP_INIT      = 3'd5;
	localparam logic [2:0] OP_IGNORED_A = 3'd6;
	localparam logic [2:0] OP_IGNORED_B = 3'd7;

	// Configuration register indexes.
	localparam logic [REG_IDX_BITS-1:0] REG_FLOOR_NORMAL       = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_LEVEL_INTERACTION  = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_LEVEL_LAUNCH       = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_CEILING_FULL       = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_CEILING_SCREEN_OFF = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_CEILING_LOW_POWER  = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_HOLD_INTERACTION   = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_HOLD_LAUNCH        = 3'd7;

	// Reset values of the configuration registers.
	localparam logic [FREQ_BITS-1:0] RST_FLOOR_NORMAL       = 22'd768000;
	localparam logic [FREQ_BITS-1:0] RST_LEVEL_INTERACTION  = 22'd1000000;
	localparam logic [FREQ_BITS-1:0] RST_LEVEL_LAUNCH       = 22'd1200000;
	localparam logic [FREQ_BITS-1:0] RST_CEILING_FULL       = 22'd1300000;
	localparam logic [FREQ_BITS-1:0] RST_CEILING_SCREEN_OFF = 22'd1000000;
	localparam logic [FREQ_BITS-1:0] RST_CEILING_LOW_POWER  = 22'd1000000;
	localparam logic [TIME_BITS-1:0] RST_HOLD_INTERACTION   = 16'd800;
	localparam logic [TIME_BITS-1:0] RST_HOLD_LAUNCH        = 16'd2000;

	// Which limit a write goes to.
	localparam logic TARGET_FLOOR   = 1'b0;
	localparam logic TARGET_CEILING = 1'b1;

	// Event word.
	typedef struct packed {
		logic [2:0] op;
		logic       flag;
	} evt_word_t;

	// Limit write word.
	typedef struct packed {
		logic                 write_target;
		logic [FREQ_BITS-1:0] write_value;
		logic                 last;
	} wr_word_t;

	// Job handed from the front to the back: wanted limits, or a forced initial write pair.
	typedef struct packed {
		logic                 init;
		logic [FREQ_BITS-1:0] ceiling;
		logic [FREQ_BITS-1:0] floor_val;
	} job_t;

endpackage

>>> src/cpu_freq_limit_booster.sv
// Top level of the CPU frequency limit booster.
// Events arrive on evt (evt_valid/evt_ready): tick, screen state, interaction,
// launch, power saving and initialize. Each event that changes the wanted limits
// produces up to two limit writes on wr (wr_valid/wr_ready), in safe order: a
// raised ceiling, then a changed floor, then a lowered ceiling; last marks the
// final write of an event. Events that change nothing produce no word.
// The front part takes one event word per cycle while its four-entry job queue
// has room. The back part issues one write word per cycle while the receiver
// takes them, and takes the next job as the last write of the current one is
// issued; a tick that ends no boost never reaches the back. Each job passes
// the queue and the job registers before the output register raises wr_valid.
// When the receiver stalls, the word waits in the output register, the back part
// stops, the queue fills and then evt_ready drops.
// Configuration registers are written on cfg (cfg_valid/cfg_ready, always ready)
// by index and should only change while the block is idle.
// Reset restores the register reset values, screen on, no boost, no power
// saving, and the applied limits to the reset floor and full ceiling.
module cpu_freq_limit_booster (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              evt_valid,
	output logic                              evt_ready,
	input  cflb_pkg::evt_word_t               evt,
	output logic                              wr_valid,
	input  logic                              wr_ready,
	output cflb_pkg::wr_word_t                wr,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [cflb_pkg::REG_IDX_BITS-1:0] cfg_index,
	input  logic [cflb_pkg::FREQ_BITS-1:0]    cfg_data
);

	logic           q_full, q_push, q_pop, q_valid;
	cflb_pkg::job_t q_in, q_out;

	assign cfg_ready = 1'b1;

	cflb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_job     (q_in)
	);

	cflb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.job_valid (q_valid),
		.job       (q_out)
	);

	cflb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (q_out),
		.pop       (q_pop),
		.wr_valid  (wr_valid),
		.wr_ready  (wr_ready),
		.wr        (wr)
	);

endmodule

>>> src/cflb_front.sv
// Front part: configuration registers, event state and computation of the wanted limits.
module cflb_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  evt_valid,
	output logic                                  evt_ready,
	input  cflb_pkg::evt_word_t                   evt,
	input  logic                                  cfg_valid,
	input  logic [cflb_pkg::REG_IDX_BITS-1:0]     cfg_index,
	input  logic [cflb_pkg::FREQ_BITS-1:0]        cfg_data,
	input  logic                                  q_full,
	output logic                                  q_push,
	output cflb_pkg::job_t                        q_job
);

	logic [cflb_pkg::FREQ_BITS-1:0] floor_normal_q, level_interaction_q, level_launch_q;
	logic [cflb_pkg::FREQ_BITS-1:0] ceiling_full_q, ceiling_screen_off_q, ceiling_low_power_q;
	logic [cflb_pkg::TIME_BITS-1:0] hold_interaction_q, hold_launch_q;

	logic                           screen_on_q, saving_q, init_done_q;
	logic [cflb_pkg::FREQ_BITS-1:0] level_q;
	logic [cflb_pkg::TIME_BITS-1:0] left_q;

	logic                           screen_on_d, saving_d, init_done_d;
	logic [cflb_pkg::FREQ_BITS-1:0] level_d;
	logic [cflb_pkg::TIME_BITS-1:0] left_d;
	logic                           want_push, want_init;
	logic [cflb_pkg::FREQ_BITS-1:0] want_ceil, base_ceil, want_floor, base_floor;
	logic                           accept;

	assign evt_ready = !q_full;
	assign accept    = evt_valid && evt_ready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_normal_q       <= cflb_pkg::RST_FLOOR_NORMAL;
			level_interaction_q  <= cflb_pkg::RST_LEVEL_INTERACTION;
			level_launch_q       <= cflb_pkg::RST_LEVEL_LAUNCH;
			ceiling_full_q       <= cflb_pkg::RST_CEILING_FULL;
			ceiling_screen_off_q <= cflb_pkg::RST_CEILING_SCREEN_OFF;
			ceiling_low_power_q  <= cflb_pkg::RST_CEILING_LOW_POWER;
			hold_interaction_q   <= cflb_pkg::RST_HOLD_INTERACTION;
			hold_launch_q        <= cflb_pkg::RST_HOLD_LAUNCH;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cflb_pkg::REG_FLOOR_NORMAL:       floor_normal_q       <= cfg_data;
				cflb_pkg::REG_LEVEL_INTERACTION:  level_interaction_q  <= cfg_data;
				cflb_pkg::REG_LEVEL_LAUNCH:       level_launch_q       <= cfg_data;
				cflb_pkg::REG_CEILING_FULL:       ceiling_full_q       <= cfg_data;
				cflb_pkg::REG_CEILING_SCREEN_OFF: ceiling_screen_off_q <= cfg_data;
				cflb_pkg::REG_CEILING_LOW_POWER:  ceiling_low_power_q  <= cfg_data;
				cflb_pkg::REG_HOLD_INTERACTION:
					hold_interaction_q <= cfg_data[cflb_pkg::TIME_BITS-1:0];
				cflb_pkg::REG_HOLD_LAUNCH:
					hold_launch_q <= cfg_data[cflb_pkg::TIME_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Next event state and whether the event needs the back part.
	always_comb begin
		screen_on_d = screen_on_q;
		saving_d    = saving_q;
		init_done_d = init_done_q;
		level_d     = level_q;
		left_d      = left_q;
		want_push   = 1'b0;
		want_init   = 1'b0;
		unique case (evt.op)
			cflb_pkg::OP_TICK: begin
				if (left_q != '0) begin
					left_d = left_q - 1'b1;
				end
				// A held boost ends once no time is left.
				if (level_q != '0 && left_d == '0) begin
					level_d   = '0;
					want_push = 1'b1;
				end
			end
			cflb_pkg::OP_SCREEN: begin
				screen_on_d = evt.flag;
				if (!evt.flag) begin
					level_d = '0;
					left_d  = '0;
				end
				want_push = 1'b1;
			end
			cflb_pkg::OP_INTERACT: begin
				if (level_interaction_q > level_q) level_d = level_interaction_q;
				if (hold_interaction_q > left_q) left_d = hold_interaction_q;
				want_push = 1'b1;
			end
			cflb_pkg::OP_LAUNCH: begin
				if (level_launch_q > level_q) level_d = level_launch_q;
				if (hold_launch_q > left_q) left_d = hold_launch_q;
				want_push = 1'b1;
			end
			cflb_pkg::OP_LOW_POWER: begin
				saving_d  = evt.flag;
				want_push = 1'b1;
			end
			cflb_pkg::OP_INIT: begin
				// Only the first initialize acts.
				if (!init_done_q) begin
					init_done_d = 1'b1;
					want_push   = 1'b1;
					want_init   = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Wanted ceiling and floor from the new state; the floor never exceeds the ceiling.
	always_comb begin
		base_ceil  = screen_on_d ? ceiling_full_q : ceiling_screen_off_q;
		want_ceil  = (saving_d && base_ceil > ceiling_low_power_q) ? ceiling_low_power_q
			: base_ceil;
		base_floor = (level_d != '0) ? level_d : floor_normal_q;
		want_floor = (base_floor > want_ceil) ? want_ceil : base_floor;
	end

	assign q_push            = accept && want_push;
	assign q_job.init        = want_init;
	assign q_job.ceiling     = want_init ? ceiling_full_q : want_ceil;
	assign q_job.floor_val   = want_init ? floor_normal_q : want_floor;

	// Event state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_on_q <= 1'b1;
			saving_q    <= 1'b0;
			init_done_q <= 1'b0;
			level_q     <= '0;
			left_q      <= '0;
		end else if (accept) begin
			screen_on_q <= screen_on_d;
			saving_q    <= saving_d;
			init_done_q <= init_done_d;
			level_q     <= level_d;
			left_q      <= left_d;
		end
	end

endmodule

>>> src/cflb_queue.sv
// Short job queue between the front and back parts.
module cflb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cflb_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           job_valid,
	output cflb_pkg::job_t job
);

	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	cflb_pkg::job_t mem_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [AW:0]    count_q;
	logic           do_push, do_pop;

	assign full      = (count_q == (AW+1)'(DEPTH));
	assign job_valid = (count_q != '0);
	assign job       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && job_valid;

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> src/cflb_back.sv
// Back part: compares wanted limits with the applied ones and issues ordered writes.
module cflb_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	input  cflb_pkg::job_t      job,
	output logic                pop,
	output logic                wr_valid,
	input  logic                wr_ready,
	output cflb_pkg::wr_word_t  wr
);

	// Pending writes: bit 0 raised ceiling, bit 1 floor, bit 2 lowered ceiling.
	logic [2:0]                     pend_q, pick, pend_after, pend_new;
	logic [cflb_pkg::FREQ_BITS-1:0] ceil_q, floor_q;
	logic [cflb_pkg::FREQ_BITS-1:0] applied_ceil_q, applied_floor_q;
	logic                           wr_valid_q;
	cflb_pkg::wr_word_t             wr_q, wr_d;
	logic                           out_free, emit, load;

	assign out_free = !wr_valid_q || wr_ready;
	assign emit     = out_free && (pend_q != '0);

	// Pick the first pending write in safe order.
	always_comb begin
		if (pend_q[0]) begin
			pick = 3'b001;
		end else if (pend_q[1]) begin
			pick = 3'b010;
		end else begin
			pick = 3'b100;
		end
		pend_after         = emit ? (pend_q & ~pick) : pend_q;
		wr_d.write_target  = pick[1] ? cflb_pkg::TARGET_FLOOR : cflb_pkg::TARGET_CEILING;
		wr_d.write_value   = pick[1] ? floor_q : ceil_q;
		wr_d.last          = ((pend_q & ~pick) == '0);
	end

	// A new job is taken once the current one has nothing left to issue.
	assign load = job_valid && (pend_after == '0);
	assign pop  = load;

	always_comb begin
		if (job.init) begin
			pend_new = 3'b011;
		end else begin
			pend_new = {job.ceiling < applied_ceil_q,
				job.floor_val != applied_floor_q,
				job.ceiling > applied_ceil_q};
		end
	end

	// Job registers and applied limits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q          <= '0;
			applied_ceil_q  <= cflb_pkg::RST_CEILING_FULL;
			applied_floor_q <= cflb_pkg::RST_FLOOR_NORMAL;
		end else if (load) begin
			pend_q          <= pend_new;
			applied_ceil_q  <= job.ceiling;
			applied_floor_q <= job.floor_val;
		end else begin
			pend_q <= pend_after;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ceil_q  <= job.ceiling;
			floor_q <= job.floor_val;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else if (emit) begin
			wr_valid_q <= 1'b1;
		end else if (wr_ready) begin
			wr_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			wr_q <= wr_d;
		end
	end

	assign wr_valid = wr_valid_q;
	assign wr       = wr_q;

endmodule

>>> src/cflb_checker.sv
// Port-level checks of the CPU frequency limit booster and their binding.
module cflb_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               evt_valid,
	input logic               evt_ready,
	input logic               wr_valid,
	input logic               wr_ready,
	input cflb_pkg::wr_word_t wr
);

	logic seen_evt_q, prev_last_q, prev_target_q;
	logic wr_acc;

	assign wr_acc = wr_valid && wr_ready;

	// Track whether any event was taken and the previous accepted write word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_evt_q    <= 1'b0;
			prev_last_q   <= 1'b1;
			prev_target_q <= cflb_pkg::TARGET_CEILING;
		end else begin
			if (evt_valid && evt_ready) seen_evt_q <= 1'b1;
			if (wr_acc) begin
				prev_last_q   <= wr.last;
				prev_target_q <= wr.write_target;
			end
		end
	end

	// A stalled write word holds.
	a_wr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid && !wr_ready |=> wr_valid && $stable(wr))
		else $error("write word changed while stalled");

	// No write appears before any event was taken.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		wr_valid |-> seen_evt_q)
		else $error("write issued without an event");

	// A raised ceiling that is not last is followed by the floor write.
	a_after_ceiling: assert property (@(posedge clk) disable iff (!arst_n)
		wr_acc && !prev_last_q && prev_target_q == cflb_pkg::TARGET_CEILING
		|-> wr.write_target == cflb_pkg::TARGET_FLOOR)
		else $error("floor write missing after raised ceiling");

	// A floor write that is not last is followed by the final lowered ceiling.
	a_after_floor: assert property (@(posedge clk) disable iff (!arst_n)
		wr_acc && !prev_last_q && prev_target_q == cflb_pkg::TARGET_FLOOR
		|-> wr.write_target == cflb_pkg::TARGET_CEILING && wr.last)
		else $error("lowered ceiling must close the event");

endmodule

bind cpu_freq_limit_booster cflb_checker u_cflb_checker (.*);

>>> test/cpu_freq_limit_booster_tb.sv
// Self-checking testbench for the CPU frequency limit booster: directed and random events.
module cpu_freq_limit_booster_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [cflb_pkg::FREQ_BITS-1:0] FREQ_ALL_ONES = {cflb_pkg::FREQ_BITS{1'b1}};
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 300000;

	logic                              clk;
	logic                              arst_n;
	logic                              evt_valid;
	logic                              evt_ready;
	cflb_pkg::evt_word_t               evt;
	logic                              wr_valid;
	logic                              wr_ready;
	cflb_pkg::wr_word_t                wr;
	logic                              cfg_valid;
	logic                              cfg_ready;
	logic [cflb_pkg::REG_IDX_BITS-1:0] cfg_index;
	logic [cflb_pkg::FREQ_BITS-1:0]    cfg_data;

	// Shadow of the configuration and of the block's state.
	logic [cflb_pkg::FREQ_BITS-1:0] cfg_shadow [8];
	logic                           scr_on;
	logic                           saving;
	logic [cflb_pkg::FREQ_BITS-1:0] boost_lvl;
	logic [cflb_pkg::TIME_BITS-1:0] boost_ticks;
	logic [cflb_pkg::FREQ_BITS-1:0] cur_floor;
	logic [cflb_pkg::FREQ_BITS-1:0] cur_ceiling;
	logic                           init_seen;

	cflb_pkg::wr_word_t pending_limit_writes [$];
	logic               mismatch_seen;
	int unsigned        cycle_count;

	// Idling controls shared by the sender, the receiver and the tests.
	int unsigned evt_gap_max;
	int unsigned wr_gap_max;
	int unsigned wr_hold_cycles;

	cpu_freq_limit_booster i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.wr_valid  (wr_valid),
		.wr_ready  (wr_ready),
		.wr        (wr),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic cflb_pkg::wr_word_t make_write(logic tgt,
		logic [cflb_pkg::FREQ_BITS-1:0] val);
		cflb_pkg::wr_word_t w;
		w.write_target = tgt;
		w.write_value  = val;
		w.last         = 1'b0;
		return w;
	endfunction

	// Update the shadow state for one event and queue the limit writes it causes.
	function automatic void predict_limit_writes(cflb_pkg::evt_word_t e);
		logic [cflb_pkg::FREQ_BITS-1:0] want_ceil;
		logic [cflb_pkg::FREQ_BITS-1:0] want_floor;
		cflb_pkg::wr_word_t             batch [3];
		int                             n;
		logic                           recompute;
		n = 0;
		recompute = 1'b0;
		case (e.op)
			cflb_pkg::OP_TICK: begin
				if (boost_ticks != 0)
					boost_ticks = boost_ticks - 1'b1;
				if (boost_lvl != 0 && boost_ticks == 0) begin
					boost_lvl = '0;
					recompute = 1'b1;
				end
			end
			cflb_pkg::OP_SCREEN: begin
				scr_on = e.flag;
				if (!e.flag) begin
					boost_lvl = '0;
					boost_ticks = '0;
				end
				recompute = 1'b1;
			end
			cflb_pkg::OP_INTERACT: begin
				if (cfg_shadow[cflb_pkg::REG_LEVEL_INTERACTION] > boost_lvl)
					boost_lvl = cfg_shadow[cflb_pkg::REG_LEVEL_INTERACTION];
				if (cfg_shadow[cflb_pkg::REG_HOLD_INTERACTION][cflb_pkg::TIME_BITS-1:0]
					> boost_ticks)
					boost_ticks =
						cfg_shadow[cflb_pkg::REG_HOLD_INTERACTION][cflb_pkg::TIME_BITS-1:0];
				recompute = 1'b1;
			end
			cflb_pkg::OP_LAUNCH: begin
				if (cfg_shadow[cflb_pkg::REG_LEVEL_LAUNCH] > boost_lvl)
					boost_lvl = cfg_shadow[cflb_pkg::REG_LEVEL_LAUNCH];
				if (cfg_shadow[cflb_pkg::REG_HOLD_LAUNCH][cflb_pkg::TIME_BITS-1:0]
					> boost_ticks)
					boost_ticks =
						cfg_shadow[cflb_pkg::REG_HOLD_LAUNCH][cflb_pkg::TIME_BITS-1:0];
				recompute = 1'b1;
			end
			cflb_pkg::OP_LOW_POWER: begin
				saving = e.flag;
				recompute = 1'b1;
			end
			cflb_pkg::OP_INIT: begin
				// Only the first initialize writes both limits unconditionally.
				if (!init_seen) begin
					batch[0] = make_write(cflb_pkg::TARGET_CEILING,
						cfg_shadow[cflb_pkg::REG_CEILING_FULL]);
					batch[1] = make_write(cflb_pkg::TARGET_FLOOR,
						cfg_shadow[cflb_pkg::REG_FLOOR_NORMAL]);
					n = 2;
					cur_ceiling = cfg_shadow[cflb_pkg::REG_CEILING_FULL];
					cur_floor = cfg_shadow[cflb_pkg::REG_FLOOR_NORMAL];
					init_seen = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Wanted limits, then the writes in safe order.
		if (recompute) begin
			want_ceil = scr_on ? cfg_shadow[cflb_pkg::REG_CEILING_FULL]
				: cfg_shadow[cflb_pkg::REG_CEILING_SCREEN_OFF];
			if (saving && want_ceil > cfg_shadow[cflb_pkg::REG_CEILING_LOW_POWER])
				want_ceil = cfg_shadow[cflb_pkg::REG_CEILING_LOW_POWER];
			want_floor = (boost_lvl != 0) ? boost_lvl : cfg_shadow[cflb_pkg::REG_FLOOR_NORMAL];
			if (want_floor > want_ceil)
				want_floor = want_ceil;
			if (want_ceil > cur_ceiling) begin
				batch[n] = make_write(cflb_pkg::TARGET_CEILING, want_ceil);
				n++;
				cur_ceiling = want_ceil;
			end
			if (want_floor != cur_floor) begin
				batch[n] = make_write(cflb_pkg::TARGET_FLOOR, want_floor);
				n++;
				cur_floor = want_floor;
			end
			if (want_ceil < cur_ceiling) begin
				batch[n] = make_write(cflb_pkg::TARGET_CEILING, want_ceil);
				n++;
				cur_ceiling = want_ceil;
			end
		end

		if (n > 0)
			batch[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			pending_limit_writes.push_back(batch[i]);
	endfunction

	// Compare one write word with the oldest expected one.
	function automatic void check_limit_write(cflb_pkg::wr_word_t got);
		cflb_pkg::wr_word_t exp;
		if (pending_limit_writes.size() == 0) begin
			$display("%0t: unexpected write word target=%0d value=%0d last=%0d",
				$time, got.write_target, got.write_value, got.last);
			mismatch_seen = 1'b1;
			return;
		end
		exp = pending_limit_writes.pop_front();
		if (got.write_target !== exp.write_target) begin
			$display("%0t: write_target expected %0d actual %0d",
				$time, exp.write_target, got.write_target);
			mismatch_seen = 1'b1;
		end
		if (got.write_value !== exp.write_value) begin
			$display("%0t: write_value expected %0d actual %0d",
				$time, exp.write_value, got.write_value);
			mismatch_seen = 1'b1;
		end
		if (got.last !== exp.last) begin
			$display("%0t: last expected %0d actual %0d", $time, exp.last, got.last);
			mismatch_seen = 1'b1;
		end
	endfunction

	// Sample every handshake at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_valid && wr_ready)
				check_limit_write(wr);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index >= cflb_pkg::REG_HOLD_INTERACTION)
					cfg_shadow[cfg_index] = {{(cflb_pkg::FREQ_BITS-cflb_pkg::TIME_BITS){1'b0}},
						cfg_data[cflb_pkg::TIME_BITS-1:0]};
				else
					cfg_shadow[cfg_index] = cfg_data;
			end
			if (evt_valid && evt_ready)
				predict_limit_writes(evt);
		end
	end

	// Run time limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Receiver: a random stall before each word, or a long hold when a test asks for one.
	initial begin
		int unsigned gap;
		wr_ready = 1'b0;
		wait (arst_n);
		forever begin
			if (wr_hold_cycles != 0) begin
				gap = wr_hold_cycles;
				wr_hold_cycles = 0;
			end else begin
				gap = $urandom_range(0, wr_gap_max);
			end
			if (gap != 0) begin
				@(negedge clk) wr_ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			@(negedge clk) wr_ready <= 1'b1;
			do @(posedge clk); while (!(wr_valid && wr_ready));
		end
	end

	// Offer one event word after a random gap and wait until it is taken.
	task automatic send_event(input logic [2:0] op, input logic flag);
		int unsigned         gap;
		cflb_pkg::evt_word_t w;
		w.op = op;
		w.flag = flag;
		gap = $urandom_range(0, evt_gap_max);
		if (gap != 0) begin
			@(negedge clk) evt_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		evt_valid <= 1'b1;
		evt <= w;
		do @(posedge clk); while (!(evt_valid && evt_ready));
	endtask

	// Stop offering events, let every expected write arrive and the pipeline empty.
	task automatic wait_idle();
		@(negedge clk) evt_valid <= 1'b0;
		while (pending_limit_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [cflb_pkg::REG_IDX_BITS-1:0] idx,
		input logic [cflb_pkg::FREQ_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk) cfg_valid <= 1'b0;
	endtask

	// Write every register: frequencies to one value, hold times to another.
	task automatic write_all_regs(input logic [cflb_pkg::FREQ_BITS-1:0] freq,
		input logic [cflb_pkg::FREQ_BITS-1:0] hold);
		for (int i = 0; i < 6; i++)
			write_reg(cflb_pkg::REG_IDX_BITS'(i), freq);
		write_reg(cflb_pkg::REG_HOLD_INTERACTION, hold);
		write_reg(cflb_pkg::REG_HOLD_LAUNCH, hold);
	endtask

	function automatic logic [cflb_pkg::FREQ_BITS-1:0] pick_freq();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return FREQ_ALL_ONES;
			2: return cflb_pkg::FREQ_BITS'($urandom_range(700000, 1400000));
			default: return cflb_pkg::FREQ_BITS'($urandom);
		endcase
	endfunction

	// Events before initialize, ignored codes, and the one-shot initialize.
	task automatic test_before_init();
		send_event(cflb_pkg::OP_TICK, 1'b1);
		send_event(cflb_pkg::OP_SCREEN, 1'b1);
		send_event(cflb_pkg::OP_INTERACT, 1'b0);
		send_event(cflb_pkg::OP_IGNORED_A, 1'b1);
		send_event(cflb_pkg::OP_IGNORED_B, 1'b0);
		send_event(cflb_pkg::OP_INIT, 1'b0);
		send_event(cflb_pkg::OP_INIT, 1'b1);
		wait_idle();
	endtask

	// Boost that counts down to its end, and a boost with no hold time.
	task automatic test_boost_expiry();
		write_reg(cflb_pkg::REG_HOLD_INTERACTION, '0);
		write_reg(cflb_pkg::REG_HOLD_LAUNCH, cflb_pkg::FREQ_BITS'(2));
		send_event(cflb_pkg::OP_LAUNCH, 1'b0);
		send_event(cflb_pkg::OP_TICK, 1'b0);
		send_event(cflb_pkg::OP_TICK, 1'b0);
		send_event(cflb_pkg::OP_INTERACT, 1'b1);
		send_event(cflb_pkg::OP_TICK, 1'b0);
		wait_idle();
	endtask

	// Screen off clears the boost; power saving bounds the ceiling.
	task automatic test_screen_and_power();
		send_event(cflb_pkg::OP_SCREEN, 1'b0);
		send_event(cflb_pkg::OP_INTERACT, 1'b0);
		send_event(cflb_pkg::OP_SCREEN, 1'b1);
		send_event(cflb_pkg::OP_LOW_POWER, 1'b1);
		send_event(cflb_pkg::OP_LOW_POWER, 1'b0);
		send_event(cflb_pkg::OP_SCREEN, 1'b0);
		wait_idle();
	endtask

	// A zero boost level, then all registers at their largest and at zero.
	task automatic test_extreme_config();
		write_reg(cflb_pkg::REG_LEVEL_INTERACTION, '0);
		send_event(cflb_pkg::OP_SCREEN, 1'b1);
		send_event(cflb_pkg::OP_INTERACT, 1'b0);
		wait_idle();
		write_all_regs(FREQ_ALL_ONES, FREQ_ALL_ONES);
		send_event(cflb_pkg::OP_LAUNCH, 1'b0);
		send_event(cflb_pkg::OP_LOW_POWER, 1'b1);
		wait_idle();
		write_all_regs('0, '0);
		send_event(cflb_pkg::OP_INTERACT, 1'b0);
		send_event(cflb_pkg::OP_LOW_POWER, 1'b0);
		send_event(cflb_pkg::OP_TICK, 1'b0);
		wait_idle();
	endtask

	// Random phases, each with its own configuration and idling.
	task automatic test_random_events();
		int unsigned sel;
		logic [2:0]  op;
		for (int phase = 0; phase < 5; phase++) begin
			for (int i = 0; i < 6; i++)
				write_reg(cflb_pkg::REG_IDX_BITS'(i), pick_freq());
			for (int i = 6; i < 8; i++) begin
				if ($urandom_range(0, 5) == 0)
					write_reg(cflb_pkg::REG_IDX_BITS'(i), cflb_pkg::FREQ_BITS'($urandom));
				else
					write_reg(cflb_pkg::REG_IDX_BITS'(i),
						cflb_pkg::FREQ_BITS'($urandom_range(0, 8)));
			end
			// One phase runs with no idling on either side.
			evt_gap_max = (phase == 2) ? 0 : 13;
			wr_gap_max = (phase == 2) ? 0 : 13;
			for (int n = 0; n < 32; n++) begin
				sel = $urandom_range(0, 9);
				op = (sel < 4) ? cflb_pkg::OP_TICK : 3'($urandom_range(1, 7));
				send_event(op, 1'($urandom));
			end
			wait_idle();
		end
		evt_gap_max = 13;
		wr_gap_max = 13;
	endtask

	// Receiver holds off while events keep coming, so the job queue fills and the input stalls.
	task automatic test_backpressure();
		write_reg(cflb_pkg::REG_FLOOR_NORMAL, cflb_pkg::RST_FLOOR_NORMAL);
		write_reg(cflb_pkg::REG_CEILING_FULL, cflb_pkg::RST_CEILING_FULL);
		write_reg(cflb_pkg::REG_CEILING_SCREEN_OFF, cflb_pkg::RST_CEILING_SCREEN_OFF);
		write_reg(cflb_pkg::REG_CEILING_LOW_POWER, FREQ_ALL_ONES);
		evt_gap_max = 0;
		wr_hold_cycles = 80;
		for (int n = 0; n < 24; n++)
			send_event(cflb_pkg::OP_SCREEN, n[0]);
		wait_idle();
		evt_gap_max = 13;
	endtask

	initial begin
		arst_n = 1'b0;
		evt_valid = 1'b0;
		evt = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatch_seen = 1'b0;
		cycle_count = 0;
		evt_gap_max = 13;
		wr_gap_max = 13;
		wr_hold_cycles = 0;

		// Shadow state at reset.
		cfg_shadow[cflb_pkg::REG_FLOOR_NORMAL] = cflb_pkg::RST_FLOOR_NORMAL;
		cfg_shadow[cflb_pkg::REG_LEVEL_INTERACTION] = cflb_pkg::RST_LEVEL_INTERACTION;
		cfg_shadow[cflb_pkg::REG_LEVEL_LAUNCH] = cflb_pkg::RST_LEVEL_LAUNCH;
		cfg_shadow[cflb_pkg::REG_CEILING_FULL] = cflb_pkg::RST_CEILING_FULL;
		cfg_shadow[cflb_pkg::REG_CEILING_SCREEN_OFF] = cflb_pkg::RST_CEILING_SCREEN_OFF;
		cfg_shadow[cflb_pkg::REG_CEILING_LOW_POWER] = cflb_pkg::RST_CEILING_LOW_POWER;
		cfg_shadow[cflb_pkg::REG_HOLD_INTERACTION] =
			cflb_pkg::FREQ_BITS'(cflb_pkg::RST_HOLD_INTERACTION);
		cfg_shadow[cflb_pkg::REG_HOLD_LAUNCH] = cflb_pkg::FREQ_BITS'(cflb_pkg::RST_HOLD_LAUNCH);
		scr_on = 1'b1;
		saving = 1'b0;
		boost_lvl = '0;
		boost_ticks = '0;
		cur_floor = cflb_pkg::RST_FLOOR_NORMAL;
		cur_ceiling = cflb_pkg::RST_CEILING_FULL;
		init_seen = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		test_before_init();
		test_boost_expiry();
		test_screen_and_power();
		test_extreme_config();
		test_random_events();
		test_backpressure();
		wait_idle();

		if (!mismatch_seen)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> cpu_freq_limit_booster.f
src/cflb_pkg.sv
src/cflb_front.sv
src/cflb_queue.sv
src/cflb_back.sv
src/cpu_freq_limit_booster.sv
src/cflb_checker.sv
test/cpu_freq_limit_booster_tb.sv
